### sv/eds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eds_pkg: shared types and constants of the entity decoder stream
// Holds the entity table, the byte and job types and the sizes that the
// front, queue and back modules share.
// ----------------------------------------------------------------------------
package eds_pkg;

   localparam int PEND_DEPTH = 6;
   localparam int ENT_COUNT  = 8;
   localparam int ENT_MAXLEN = 7;
   localparam int QDEPTH     = 2;

   typedef logic [7:0] byte_type;
   typedef logic [2:0] count_type;

   localparam byte_type AMP = 8'h26;

   // One unit of output work: some held bytes, then optionally one more byte.
   typedef struct packed {
      byte_type [PEND_DEPTH-1:0] pend;
      count_type                 pcnt;
      byte_type                  tail;
      logic                      tail_en;
      logic                      last;
   } job_type;

   localparam byte_type ENT_TEXT [ENT_COUNT][ENT_MAXLEN] = '{
      '{"&", "t", "a", "b", ";", 8'h00, 8'h00},
      '{"&", "d", "q", "u", "o", "t", ";"},
      '{"&", "q", "u", "o", "t", ";", 8'h00},
      '{"&", "o", "p", "e", "n", ";", 8'h00},
      '{"&", "c", "l", "o", "s", "e", ";"},
      '{"&", "s", "q", "u", "o", "t", ";"},
      '{"&", "c", "o", "m", "m", "a", ";"},
      '{"&", "c", "o", "l", "o", "n", ";"}
   };

   localparam count_type ENT_LEN [ENT_COUNT] = '{
      3'd5, 3'd7, 3'd6, 3'd6, 3'd7, 3'd7, 3'd7, 3'd7
   };

   localparam byte_type ENT_REPL [ENT_COUNT] = '{
      8'h09, 8'h22, 8'h27, 8'h5B, 8'h5D, 8'h27, 8'h2C, 8'h3A
   };

endpackage
`default_nettype wire

### sv/eds_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eds_front: input side of the entity decoder
// Accepts one byte per cycle while the job queue is not full, tracks the held
// entity prefix and turns each byte into at most one job for the output side.
// ----------------------------------------------------------------------------
module eds_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire logic [7:0]      req_tdata,
   input  wire logic            req_tlast,
   input  wire logic            q_full,
   output logic                 job_push,
   output eds_pkg::job_type     job
);
   import eds_pkg::*;

   count_type                 cnt_ff, cnt_in;
   logic [ENT_COUNT-1:0]      mask_ff, mask_in;
   byte_type [PEND_DEPTH-1:0] pend_ff;
   logic                      pend_wr;
   count_type                 pend_wr_idx;

   logic [ENT_COUNT-1:0]      hit;
   logic                      full_any, pref_any, accept;
   byte_type                  repl;
   count_type                 cnt_p1;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;
   assign cnt_p1     = cnt_ff + 3'd1;

   // Match the new byte against every entity that the held prefix still fits.
   always_comb begin
      full_any = 1'b0;
      pref_any = 1'b0;
      repl     = 8'h00;
      for (int e = 0; e < ENT_COUNT; e++) begin
         hit[e] = mask_ff[e] && (cnt_ff < ENT_LEN[e]) && (ENT_TEXT[e][cnt_ff] == req_tdata);
         if (hit[e] && (ENT_LEN[e] == cnt_p1)) begin
            full_any = 1'b1;
            repl     = repl | ENT_REPL[e];
         end
         if (hit[e] && (ENT_LEN[e] != cnt_p1)) begin
            pref_any = 1'b1;
         end
      end
   end

   always_comb begin
      cnt_in      = cnt_ff;
      mask_in     = mask_ff;
      pend_wr     = 1'b0;
      pend_wr_idx = 3'd0;
      job_push    = 1'b0;
      job.pend    = pend_ff;
      job.pcnt    = 3'd0;
      job.tail    = req_tdata;
      job.tail_en = 1'b1;
      job.last    = req_tlast;
      if (accept) begin
         if (cnt_ff == 3'd0) begin
            if (req_tdata == AMP && !req_tlast) begin
               cnt_in  = 3'd1;
               mask_in = '1;
               pend_wr = 1'b1;
            end else begin
               job_push = 1'b1;
            end
         end else if (full_any) begin
            cnt_in   = 3'd0;
            job.tail = repl;
            job_push = 1'b1;
         end else if (pref_any && cnt_ff < 3'(PEND_DEPTH)) begin
            if (req_tlast) begin
               cnt_in   = 3'd0;
               job.pcnt = cnt_ff;
               job_push = 1'b1;
            end else begin
               cnt_in      = cnt_p1;
               mask_in     = hit;
               pend_wr     = 1'b1;
               pend_wr_idx = cnt_ff;
            end
         end else begin
            // Mismatch: release the held bytes; a new ampersand starts over.
            job.pcnt = cnt_ff;
            job_push = 1'b1;
            if (req_tdata == AMP && !req_tlast) begin
               job.tail_en = 1'b0;
               cnt_in      = 3'd1;
               mask_in     = '1;
               pend_wr     = 1'b1;
            end else begin
               cnt_in = 3'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      if (pend_wr) begin
         pend_ff[pend_wr_idx] <= req_tdata;
      end
   end

endmodule
`default_nettype wire

### sv/eds_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eds_queue: short job queue between the front and back
// A two-entry FIFO that lets the input and output sides stall independently.
// ----------------------------------------------------------------------------
module eds_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire eds_pkg::job_type push_job,
   input  wire logic             pop,
   output eds_pkg::job_type      head_job,
   output logic                  full,
   output logic                  empty
);
   import eds_pkg::*;

   localparam int PW = $clog2(QDEPTH);

   job_type          mem_ff [QDEPTH];
   logic [PW-1:0]    wp_ff, rp_ff;
   logic [PW:0]      cnt_ff;

   assign full     = (cnt_ff == (PW+1)'(QDEPTH));
   assign empty    = (cnt_ff == '0);
   assign head_job = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= (wp_ff == PW'(QDEPTH - 1)) ? '0 : wp_ff + 1'b1;
         end
         if (pop) begin
            rp_ff <= (rp_ff == PW'(QDEPTH - 1)) ? '0 : rp_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

### sv/eds_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eds_back: output side of the entity decoder
// Walks the head job to the output register one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module eds_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire eds_pkg::job_type head_job,
   input  wire logic             empty,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast
);
   import eds_pkg::*;

   count_type idx_ff;
   count_type total;
   logic      is_end, emit;
   byte_type  cur_byte;
   logic      valid_ff;
   byte_type  data_ff;
   logic      last_ff;

   assign total    = head_job.pcnt + {2'b00, head_job.tail_en};
   assign is_end   = (idx_ff == total - 3'd1);
   assign cur_byte = (idx_ff < head_job.pcnt) ? head_job.pend[idx_ff] : head_job.tail;
   assign emit     = !empty && (!valid_ff || rsp_tready);
   assign pop      = emit && is_end;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            idx_ff <= is_end ? 3'd0 : idx_ff + 3'd1;
         end
         if (emit) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         data_ff <= cur_byte;
         last_ff <= head_job.last && is_end;
      end
   end

endmodule
`default_nettype wire

### sv/entity_decoder_stream.sv
`default_nettype none
// Output path: a word that yields output goes into the job queue, then the output register.
// Flow: one input word per cycle while the job queue has room and each word yields at
// most one output word; a mismatch that releases held bytes occupies the output one byte
// at a time (up to seven bytes), and the two-entry job queue then backs up req_tready.
// Reset: synchronous, active high; clears the held-prefix count, queue and output.
// ----------------------------------------------------------------------------
// entity_decoder_stream: streaming decoder for eight fixed text entities
// Replaces complete entities such as &tab; or &comma; with single characters
// and passes every other byte through unchanged.
// ----------------------------------------------------------------------------
module entity_decoder_stream (
   input  wire logic       clock,
   input  wire logic       reset,
   // Input stream of encoded text.
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_byte
   input  wire logic       req_tlast,   // in_last
   // Output stream of decoded text.
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic            rsp_tlast    // out_last
);
   import eds_pkg::*;

   // The front holds up to six bytes that may still become an entity and
   // decides, for each accepted word, what to release: nothing, one byte,
   // or the held bytes followed optionally by the new byte. Each release is
   // one job in the queue.
   job_type push_job, head_job;
   logic    push, pop, q_full, q_empty;

   eds_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .job_push   (push),
      .job        (push_job)
   );

   // The queue decouples the two sides so that a long release does not stop
   // the front from classifying the next word right away.
   eds_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   // The back serializes the head job into the registered output word and
   // marks the final word of a value with tlast.
   eds_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .empty      (q_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the entity decoder stream
// Feeds encoded text bytes with random pacing on both sides. It keeps its own
// decoder of the eight entities and compares every output word, field by field,
// with the oldest decoded byte still owed.
// ----------------------------------------------------------------------------
module tb_top;

   // An ampersand opens every entity, and a new one restarts the held prefix.
   localparam logic [7:0] AMPERSAND = 8'h26;
   localparam int HELD_DEPTH = 6;
   localparam int ENTITY_COUNT = 8;

   // One queued input word. The hold flag makes the sender wait until every
   // decoded byte owed so far has come back before this word goes out.
   typedef struct packed {
      logic       hold;
      logic       fin;
      logic [7:0] data;
   } text_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] in_byte
   logic       req_tlast = 1'b0;    // in_last
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic       rsp_tlast;           // out_last

   // The entities and the characters that replace them.
   string entity_text [ENTITY_COUNT] = '{
      "&tab;", "&dquot;", "&quot;", "&open;", "&close;", "&squot;", "&comma;", "&colon;"
   };
   logic [7:0] entity_repl [ENTITY_COUNT] = '{
      8'h09, 8'h22, 8'h27, 8'h5B, 8'h5D, 8'h27, 8'h2C, 8'h3A
   };

   text_word_type text_q [$];
   text_word_type next_word;
   bit            hold_next = 1'b0;

   // Decoded bytes still owed by the block, each as {out_last, out_byte}.
   logic [8:0] decoded_q [$];
   logic [8:0] owed;
   logic [7:0] held_bytes [HELD_DEPTH];
   int         held_cnt = 0;

   int results_owed = 0;
   bit calm = 1'b0;
   int gap_left = 0;
   int stall_left = 0;
   int mismatches = 0;

   entity_decoder_stream uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Appends one decoded byte to the tail of the owed queue.
   task automatic owe_byte(input logic [8:0] w);
      decoded_q.insert(decoded_q.size(), w);
   endtask

   // Releases every held prefix byte unchanged, oldest first.
   task automatic flush_held();
      for (int i = 0; i < held_cnt; i++) begin
         owe_byte({1'b0, held_bytes[i]});
      end
      held_cnt = 0;
   endtask

   // Decodes one accepted input word and appends what it releases to the
   // owed queue. A prefix is kept only while some entity can still grow from
   // it; a complete entity collapses to its replacement character.
   task automatic decode_byte(input logic [7:0] b, input logic fin);
      logic [7:0] cand [HELD_DEPTH+1];
      logic [7:0] repl;
      int         len;
      int         first;
      bit         full;
      bit         grow;
      bit         same;
      first = decoded_q.size();
      if (held_cnt == 0) begin
         if (b == AMPERSAND) begin
            held_bytes[0] = b;
            held_cnt = 1;
         end else begin
            owe_byte({1'b0, b});
         end
      end else begin
         len = held_cnt + 1;
         full = 1'b0;
         grow = 1'b0;
         repl = 8'h00;
         for (int i = 0; i < held_cnt; i++) begin
            cand[i] = held_bytes[i];
         end
         cand[held_cnt] = b;
         for (int e = 0; e < ENTITY_COUNT; e++) begin
            if (entity_text[e].len() >= len) begin
               same = 1'b1;
               for (int i = 0; i < len; i++) begin
                  if (entity_text[e][i] != cand[i]) same = 1'b0;
               end
               if (same && entity_text[e].len() == len) begin
                  full = 1'b1;
                  repl = entity_repl[e];
               end else if (same) begin
                  grow = 1'b1;
               end
            end
         end
         if (full) begin
            held_cnt = 0;
            owe_byte({1'b0, repl});
         end else if (grow && len <= HELD_DEPTH) begin
            held_bytes[held_cnt] = b;
            held_cnt = len;
         end else begin
            // Mismatch: the prefix goes out as it was, and an ampersand
            // starts a fresh one instead of passing through.
            flush_held();
            if (b == AMPERSAND) begin
               held_bytes[0] = b;
               held_cnt = 1;
            end else begin
               owe_byte({1'b0, b});
            end
         end
      end
      // The final byte of a value drains the prefix and marks the last
      // decoded byte of this step.
      if (fin) begin
         flush_held();
         if (decoded_q.size() > first) begin
            decoded_q[decoded_q.size() - 1][8] = 1'b1;
         end
      end
   endtask

   task automatic push_byte(input logic [7:0] b, input bit fin);
      text_word_type w;
      w = '{hold: hold_next, fin: fin, data: b};
      text_q.insert(text_q.size(), w);
      hold_next = 1'b0;
   endtask

   // Queues the first count characters of s; fin marks the last of them.
   task automatic push_text(input string s, input int count, input bit fin);
      for (int i = 0; i < count; i++) begin
         push_byte(s[i], fin && (i == count - 1));
      end
   endtask

   // Driver. A new word is offered once the previous one is taken; random
   // gaps follow some words, except near the end.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (text_q.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (text_q[0].hold && (req_tvalid || results_owed != 0)) begin
            // Drain point: wait for a quiet input and an empty owed queue.
            req_tvalid <= 1'b0;
         end else begin
            next_word = text_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_word.data;
            req_tlast  <= next_word.fin;
            if (!calm && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 15);
         end
      end
      calm <= (text_q.size() < 25);
   end

   // Monitor. Predicts from each accepted input word first, so that the owed
   // queue is filled before any output word at the same edge is checked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (req_tvalid && req_tready) decode_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected word byte=%h last=%b",
                           $realtime, rsp_tdata, rsp_tlast);
            end else begin
               owed = decoded_q.pop_front();
               if (rsp_tdata !== owed[7:0] || rsp_tlast !== owed[8]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch byte exp=%h got=%h, last exp=%b got=%b",
                              $realtime, owed[7:0], rsp_tdata, owed[8], rsp_tlast);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm && $urandom_range(0, 6) == 0) stall_left = $urandom_range(1, 15);
         end
      end
      results_owed <= decoded_q.size();
   end

   // Stimulus and end of run.
   initial begin
      int         kind;
      int         e;
      int         k;
      bit         fin;

      // Directed words: whole entities, a mismatch, an ampersand that
      // interrupts a prefix, both byte extremes, a value that ends with a
      // held prefix, and a value that starts right after a final byte.
      push_text("&tab;", 5, 1'b0);
      push_text("&colon;", 7, 1'b0);
      push_text("&cx", 3, 1'b0);
      push_text("&&;", 3, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b1);
      push_text("&squo", 5, 1'b1);

      // Random part: mostly entities and near misses, the rest noise.
      hold_next = 1'b1;
      while (text_q.size() < 210) begin
         if (text_q.size() >= 120 && text_q.size() < 126) hold_next = 1'b1;
         kind = $urandom_range(0, 9);
         e = $urandom_range(0, ENTITY_COUNT - 1);
         fin = ($urandom_range(0, 4) == 0);
         if (kind <= 3) begin
            push_text(entity_text[e], entity_text[e].len(), fin);
         end else if (kind <= 5) begin
            // A prefix that breaks off; up to six held bytes then a stray byte.
            k = $urandom_range(1, entity_text[e].len() - 1);
            push_text(entity_text[e], k, 1'b0);
            push_byte(8'($urandom_range(0, 255)), fin);
         end else if (kind == 6) begin
            k = $urandom_range(1, entity_text[e].len() - 1);
            push_text(entity_text[e], k, 1'b0);
            push_byte(AMPERSAND, fin);
         end else if (kind == 7) begin
            k = $urandom_range(1, 4);
            for (int i = 0; i < k; i++)
               push_byte(8'($urandom_range(0, 255)), fin && i == k - 1);
         end else if (kind == 8) begin
            push_byte(AMPERSAND, fin);
         end else begin
            push_byte(entity_text[e][$urandom_range(1, 4)], fin);
         end
      end
      // The run ends on a final byte so that no prefix stays held.
      text_q[text_q.size() - 1].fin = 1'b1;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Sampled between edges, once all clocked updates have settled.
      do @(negedge clock);
      while (text_q.size() != 0 || req_tvalid || decoded_q.size() != 0);
      repeat (20) @(negedge clock);

      if (mismatches == 0 && decoded_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #3000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

### filelist.f
sv/eds_pkg.sv
sv/eds_front.sv
sv/eds_queue.sv
sv/eds_back.sv
sv/entity_decoder_stream.sv
sim/tb_top.sv
